// ----- src/omni_mix_pkg.sv -----
package omni_mix_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TAB_LEN = 24;

	localparam int AW = 32;
	localparam int VW = 35;
	localparam int RW = 34;
	localparam int ZW = 34;
	localparam int DW = 35;
	localparam int QW = 32;
	localparam int PW = RW + 16;
	localparam int TW = 33;
	localparam int MW = TW + QW + 1;
	localparam int NW = 34;
	localparam int SW = 18;
	localparam int WW = NW + SW;
	localparam int FW = WW + 1;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] LOW_LIMIT_RST = 16'd3277;
	localparam logic [CFG_W-1:0] OUTPUT_MAX_RST = 16'd32768;

	localparam logic [AW-1:0] EIGHTH_TURN = 32'h2000_0000;
	localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(32'h4000_0000);
	localparam logic signed [ZW-1:0] Z_HALF = ZW'(32'h8000_0000);
	localparam logic signed [RW-1:0] INV_GAIN = RW'(32'h26DD_3B6A);
	localparam logic [63:0] DIV_NUM = 64'd1518500250 << 30;
	localparam logic [QW-1:0] FIX_ONE = 32'h4000_0000;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] om;
		logic [15:0] head;
		logic rot;
	} ctx_t;

	typedef struct packed {
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
		logic signed [ZW-1:0] z;
	} rv_t;

	typedef struct packed {
		ctx_t c;
		logic [30:0] xx;
		logic [30:0] yy;
		logic [31:0] ll2;
	} ent_t;

	typedef struct packed {
		ctx_t c;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic [AW-1:0] vz;
		logic vzero;
	} vec_t;

	typedef struct packed {
		ctx_t c;
		rv_t r1;
		rv_t r2;
	} rot_t;

	typedef struct packed {
		ctx_t c;
		logic signed [RW-1:0] cs;
		logic signed [RW-1:0] sn;
		logic [DW-1:0] den;
		logic [DW:0] rem;
		logic [QW-1:0] q;
		logic dz;
	} div_t;

	typedef struct packed {
		ctx_t c;
		logic signed [PW-1:0] xs;
		logic signed [PW-1:0] yc;
		logic signed [PW-1:0] xc;
		logic signed [PW-1:0] ys;
		logic [QW-1:0] fix;
	} mul_t;

	typedef struct packed {
		ctx_t c;
		logic [3:0][TW-1:0] r;
		logic [QW-1:0] fix;
	} rnd_t;

	typedef struct packed {
		ctx_t c;
		logic [3:0][MW-1:0] m;
	} mfx_t;

	typedef struct packed {
		ctx_t c;
		logic [3:0][NW-1:0] v;
	} nrm_t;

	typedef struct packed {
		ctx_t c;
		logic [3:0][WW-1:0] w;
	} scl_t;

	typedef struct packed {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
		logic signed [15:0] d;
		logic rot;
	} res_t;

	function automatic logic [AW-1:0] atan_entry(input int unsigned i);
		logic [AW-1:0] v;
		v = '0;
		if (i < TAB_LEN) begin
			case (i)
				0: v = 32'h2000_0000;
				1: v = 32'h12E4_051E;
				2: v = 32'h09FB_385B;
				3: v = 32'h0511_11D4;
				4: v = 32'h028B_0D43;
				5: v = 32'h0145_D7E1;
				6: v = 32'h00A2_F61E;
				7: v = 32'h0051_7C55;
				8: v = 32'h0028_BE53;
				9: v = 32'h0014_5F2F;
				10: v = 32'h000A_2F98;
				11: v = 32'h0005_17CC;
				12: v = 32'h0002_8BE6;
				13: v = 32'h0001_45F3;
				14: v = 32'h0000_A2FA;
				15: v = 32'h0000_517D;
				16: v = 32'h0000_28BE;
				17: v = 32'h0000_145F;
				18: v = 32'h0000_0A30;
				19: v = 32'h0000_0518;
				20: v = 32'h0000_028C;
				21: v = 32'h0000_0146;
				22: v = 32'h0000_00A3;
				23: v = 32'h0000_0051;
				default: v = '0;
			endcase
		end
		return v;
	endfunction

	function automatic rv_t fold_angle(input logic [AW-1:0] ang);
		rv_t r;
		r.z = ZW'(signed'(ang));
		r.x = INV_GAIN;
		r.y = '0;
		if (r.z > Z_QUARTER) begin
			r.z = r.z - Z_HALF;
			r.x = -INV_GAIN;
		end else if (r.z < -Z_QUARTER) begin
			r.z = r.z + Z_HALF;
			r.x = -INV_GAIN;
		end
		return r;
	endfunction

	function automatic rv_t rot_step(input rv_t v, input int unsigned sh, input logic [AW-1:0] ang);
		rv_t n;
		logic signed [RW-1:0] dx;
		logic signed [RW-1:0] dy;
		dx = v.y >>> sh;
		dy = v.x >>> sh;
		if (v.z >= 0) begin
			n.x = v.x - dx;
			n.y = v.y + dy;
			n.z = v.z - ZW'(ang);
		end else begin
			n.x = v.x + dx;
			n.y = v.y - dy;
			n.z = v.z + ZW'(ang);
		end
		return n;
	endfunction

	function automatic logic signed [TW-1:0] rnd15(input logic signed [PW:0] v);
		logic signed [PW+1:0] t;
		t = (PW+2)'(v) + (PW+2)'(16384);
		return TW'(t >>> 15);
	endfunction

	function automatic logic signed [NW-1:0] rnd30(input logic signed [MW-1:0] v);
		logic signed [MW:0] t;
		t = (MW+1)'(v) + ((MW+1)'(1) <<< 29);
		return NW'(t >>> 30);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		logic signed [15:0] r;
		if (v > 21'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -21'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

	function automatic logic signed [15:0] rnd32_sat(input logic signed [FW-1:0] v);
		logic signed [FW:0] t;
		t = (FW+1)'(v) + ((FW+1)'(1) <<< 31);
		return sat16(21'(t >>> 32));
	endfunction

endpackage

// ----- src/omni_mix_if.sv -----
interface omni_mix_cmd_if;
	logic valid;
	logic ready;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic [15:0] heading;
	logic signed [15:0] rotate_rate;

	modport source(output valid, vel_x, vel_y, heading, rotate_rate, input ready);
	modport sink(input valid, vel_x, vel_y, heading, rotate_rate, output ready);
endinterface

interface omni_mix_res_if;
	logic valid;
	logic ready;
	logic signed [15:0] wheel_a_drive;
	logic signed [15:0] wheel_b_drive;
	logic signed [15:0] wheel_c_drive;
	logic signed [15:0] wheel_d_drive;
	logic rotation_only;

	modport source(output valid, wheel_a_drive, wheel_b_drive, wheel_c_drive, wheel_d_drive,
		rotation_only, input ready);
	modport sink(input valid, wheel_a_drive, wheel_b_drive, wheel_c_drive, wheel_d_drive,
		rotation_only, output ready);
endinterface

// ----- src/omni_wheel_vector_mixer.sv -----
// Four-wheel omni base mixer: each command transaction (vel_x, vel_y, heading, rotate_rate)
// yields one result transaction with four wheel drive values in Q3.13 and a rotation-only flag.
// The datapath is a single pipeline of 2*CORDIC_STAGES+42 register stages: a squared-magnitude
// test, a vectoring CORDIC for the command direction, two rotation CORDICs side by side, a
// 32-step restoring divider for the sqrt2/(|sin|+|cos|) correction and six multiply and
// rounding stages. A new command is taken every cycle while the holding register is empty
// (one transaction per cycle); that register sits behind the last stage and captures a result
// that the result side refuses; the whole pipeline then holds until it is taken. The user must
// write low_limit and output_max through the cfg port while idle; the block does not check.
module omni_wheel_vector_mixer import omni_mix_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_W-1:0] cfg_wdata,
	omni_mix_cmd_if.sink cmd,
	omni_mix_res_if.source res
);

	localparam int NS = CORDIC_STAGES;
	localparam int NST = 2 * NS + 42;

	logic [CFG_W-1:0] low_limit_q;
	logic [CFG_W-1:0] output_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q <= LOW_LIMIT_RST;
			output_max_q <= OUTPUT_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LOW_LIMIT: low_limit_q <= cfg_wdata;
				REG_OUTPUT_MAX: output_max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic en;
	logic [NST-1:0] vld_q;
	logic skid_vld_q;
	res_t skid_q;

	assign en = !skid_vld_q;
	assign cmd.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], cmd.valid};
		end
	end

	ent_t ent_s0;
	logic signed [31:0] sq_x;
	logic signed [31:0] sq_y;
	logic [31:0] ll2;

	assign sq_x = 32'(cmd.vel_x) * 32'(cmd.vel_x);
	assign sq_y = 32'(cmd.vel_y) * 32'(cmd.vel_y);
	assign ll2 = 32'(low_limit_q) * 32'(low_limit_q);

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s0.c.x <= cmd.vel_x;
			ent_s0.c.y <= cmd.vel_y;
			ent_s0.c.om <= cmd.rotate_rate;
			ent_s0.c.head <= cmd.heading;
			ent_s0.c.rot <= 1'b0;
			ent_s0.xx <= 31'(sq_x);
			ent_s0.yy <= 31'(sq_y);
			ent_s0.ll2 <= ll2;
		end
	end

	vec_t vec_s [0:NS];
	vec_t vec_init;
	logic [31:0] msum;

	always_comb begin
		msum = 32'(ent_s0.xx) + 32'(ent_s0.yy);
		vec_init.c = ent_s0.c;
		vec_init.c.rot = {msum, 2'b00} < 34'(ent_s0.ll2);
		vec_init.vx = VW'(ent_s0.c.x) <<< 16;
		vec_init.vy = VW'(ent_s0.c.y) <<< 16;
		vec_init.vz = '0;
		vec_init.vzero = (ent_s0.c.x == 16'sd0) && (ent_s0.c.y == 16'sd0);
		if (ent_s0.c.x < 16'sd0) begin
			vec_init.vx = -vec_init.vx;
			vec_init.vy = -vec_init.vy;
			vec_init.vz = HALF_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0] <= vec_init;
		end
	end

	for (genvar j = 1; j <= NS; j++) begin : g_vec
		localparam int SH = j - 1;
		vec_t nxt;
		always_comb begin
			nxt = vec_s[j-1];
			if (vec_s[j-1].vy > 0) begin
				nxt.vx = vec_s[j-1].vx + (vec_s[j-1].vy >>> SH);
				nxt.vy = vec_s[j-1].vy - (vec_s[j-1].vx >>> SH);
				nxt.vz = vec_s[j-1].vz + atan_entry(SH);
			end else begin
				nxt.vx = vec_s[j-1].vx - (vec_s[j-1].vy >>> SH);
				nxt.vy = vec_s[j-1].vy + (vec_s[j-1].vx >>> SH);
				nxt.vz = vec_s[j-1].vz - atan_entry(SH);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[j] <= nxt;
			end
		end
	end

	rot_t rot_s [0:NS];
	rot_t rot_init;
	logic [AW-1:0] head32;
	logic [AW-1:0] dir;

	always_comb begin
		head32 = {vec_s[NS].c.head, 16'h0000};
		dir = vec_s[NS].vzero ? '0 : vec_s[NS].vz;
		rot_init.c = vec_s[NS].c;
		rot_init.r1 = fold_angle(head32 + EIGHTH_TURN);
		rot_init.r2 = fold_angle(head32 + dir);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s[0] <= rot_init;
		end
	end

	for (genvar j = 1; j <= NS; j++) begin : g_rot
		localparam int SH = j - 1;
		rot_t nxt;
		always_comb begin
			nxt.c = rot_s[j-1].c;
			nxt.r1 = rot_step(rot_s[j-1].r1, SH, atan_entry(SH));
			nxt.r2 = rot_step(rot_s[j-1].r2, SH, atan_entry(SH));
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rot_s[j] <= nxt;
			end
		end
	end

	div_t div_s [0:QW];
	div_t div_init;
	logic [RW-1:0] abs_c2;
	logic [RW-1:0] abs_s2;

	always_comb begin
		abs_c2 = (rot_s[NS].r2.x < 0) ? RW'(-rot_s[NS].r2.x) : RW'(rot_s[NS].r2.x);
		abs_s2 = (rot_s[NS].r2.y < 0) ? RW'(-rot_s[NS].r2.y) : RW'(rot_s[NS].r2.y);
		div_init.c = rot_s[NS].c;
		div_init.cs = rot_s[NS].r1.x;
		div_init.sn = rot_s[NS].r1.y;
		div_init.den = DW'(abs_c2) + DW'(abs_s2);
		div_init.rem = (DW+1)'(DIV_NUM >> QW);
		div_init.q = '0;
		div_init.dz = (div_init.den == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= div_init;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int B = QW - j;
		div_t nxt;
		logic [DW:0] t;
		always_comb begin
			nxt = div_s[j-1];
			t = {div_s[j-1].rem[DW-1:0], DIV_NUM[B]};
			if (t >= {1'b0, div_s[j-1].den}) begin
				nxt.rem = t - {1'b0, div_s[j-1].den};
				nxt.q[B] = 1'b1;
			end else begin
				nxt.rem = t;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j] <= nxt;
			end
		end
	end

	mul_t mul_s1;
	rnd_t rnd_s2;
	mfx_t mfx_s3;
	nrm_t nrm_s4;
	scl_t scl_s5;
	res_t out_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s1.c <= div_s[QW].c;
			mul_s1.xs <= PW'(div_s[QW].c.x) * PW'(div_s[QW].sn);
			mul_s1.yc <= PW'(div_s[QW].c.y) * PW'(div_s[QW].cs);
			mul_s1.xc <= PW'(div_s[QW].c.x) * PW'(div_s[QW].cs);
			mul_s1.ys <= PW'(div_s[QW].c.y) * PW'(div_s[QW].sn);
			mul_s1.fix <= div_s[QW].dz ? FIX_ONE : div_s[QW].q;
		end
	end

	logic signed [PW:0] ta;
	logic signed [PW:0] tb;

	always_comb begin
		ta = (PW+1)'(mul_s1.yc) - (PW+1)'(mul_s1.xs);
		tb = -((PW+1)'(mul_s1.xc) + (PW+1)'(mul_s1.ys));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s2.c <= mul_s1.c;
			rnd_s2.fix <= mul_s1.fix;
			rnd_s2.r[0] <= rnd15(ta);
			rnd_s2.r[1] <= rnd15(tb);
			rnd_s2.r[2] <= rnd15(-ta);
			rnd_s2.r[3] <= rnd15(-tb);
		end
	end

	logic signed [MW-1:0] fix_ext;
	assign fix_ext = signed'(MW'(rnd_s2.fix));

	always_ff @(posedge clk) begin
		if (en) begin
			mfx_s3.c <= rnd_s2.c;
			for (int k = 0; k < 4; k++) begin
				mfx_s3.m[k] <= MW'(signed'(rnd_s2.r[k])) * fix_ext;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s4.c <= mfx_s3.c;
			for (int k = 0; k < 4; k++) begin
				nrm_s4.v[k] <= rnd30(signed'(mfx_s3.m[k]));
			end
		end
	end

	logic [16:0] abs_om;
	logic signed [SW-1:0] scale;

	always_comb begin
		abs_om = (nrm_s4.c.om < 0) ? 17'(-(17'(nrm_s4.c.om))) : 17'(nrm_s4.c.om);
		scale = signed'(SW'(output_max_q)) - signed'(SW'(abs_om));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scl_s5.c <= nrm_s4.c;
			for (int k = 0; k < 4; k++) begin
				scl_s5.w[k] <= WW'(signed'(nrm_s4.v[k])) * WW'(scale);
			end
		end
	end

	logic signed [FW-1:0] om_q30;
	logic signed [3:0][15:0] wheel;
	logic signed [17:0] rot_sum;
	logic signed [15:0] rot_val;

	always_comb begin
		om_q30 = FW'(scl_s5.c.om) <<< 30;
		for (int k = 0; k < 4; k++) begin
			wheel[k] = rnd32_sat(FW'(signed'(scl_s5.w[k])) + om_q30);
		end
		rot_sum = (18'(scl_s5.c.om) + 18'sd2) >>> 2;
		rot_val = 16'(rot_sum);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s6.rot <= scl_s5.c.rot;
			out_s6.a <= scl_s5.c.rot ? rot_val : signed'(wheel[0]);
			out_s6.b <= scl_s5.c.rot ? rot_val : signed'(wheel[1]);
			out_s6.c <= scl_s5.c.rot ? rot_val : signed'(wheel[2]);
			out_s6.d <= scl_s5.c.rot ? rot_val : signed'(wheel[3]);
		end
	end

	// hold the last result while the pipeline moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (res.ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_q[NST-1] && !res.ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_q[NST-1] && !res.ready) begin
			skid_q <= out_s6;
		end
	end

	res_t res_sel;
	assign res_sel = skid_vld_q ? skid_q : out_s6;

	assign res.valid = skid_vld_q || vld_q[NST-1];
	assign res.wheel_a_drive = res_sel.a;
	assign res.wheel_b_drive = res_sel.b;
	assign res.wheel_c_drive = res_sel.c;
	assign res.wheel_d_drive = res_sel.d;
	assign res.rotation_only = res_sel.rot;

endmodule

// ----- src/omni_mix_chk.sv -----
module omni_mix_chk (
	input logic clk,
	input logic arst_n,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input logic signed [15:0] wheel_a_drive,
	input logic signed [15:0] wheel_b_drive,
	input logic signed [15:0] wheel_c_drive,
	input logic signed [15:0] wheel_d_drive,
	input logic rotation_only
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({wheel_a_drive, wheel_b_drive, wheel_c_drive,
			wheel_d_drive, rotation_only}))
		else $error("result changed while stalled");

	a_rot_equal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rotation_only |-> wheel_b_drive == wheel_a_drive
			&& wheel_c_drive == wheel_a_drive && wheel_d_drive == wheel_a_drive)
		else $error("rotation-only wheels differ");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("command side stalled with no result pending");

endmodule

bind omni_wheel_vector_mixer omni_mix_chk u_omni_mix_chk (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_ready(cmd.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.wheel_a_drive(res.wheel_a_drive),
	.wheel_b_drive(res.wheel_b_drive),
	.wheel_c_drive(res.wheel_c_drive),
	.wheel_d_drive(res.wheel_d_drive),
	.rotation_only(res.rotation_only)
);

// ----- tb/omni_wheel_vector_mixer_tb.sv -----
module omni_wheel_vector_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import omni_mix_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
	localparam int PIPE_DEPTH = 2 * CORDIC_STAGES_DEF + 42;

	class wheel_mix_scoreboard;
		static const bit [31:0] ATAN_STEP [24] = '{
			32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
			32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
			32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
			32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
			32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
			32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051};
		res_t wheels_due[$];
		int unsigned errors;
		logic [15:0] low_lim;
		logic [15:0] out_max;

		function new();
			errors = 0;
			low_lim = LOW_LIMIT_RST;
			out_max = OUTPUT_MAX_RST;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == REG_LOW_LIMIT) begin
				low_lim = val;
			end else if (idx == REG_OUTPUT_MAX) begin
				out_max = val;
			end
		endfunction

		function longint rnd_shr(longint v, int n);
			return (v + (longint'(1) <<< (n - 1))) >>> n;
		endfunction

		function logic signed [15:0] clamp16(longint v);
			if (v > 32767) begin
				return 16'sh7FFF;
			end else if (v < -32768) begin
				return 16'sh8000;
			end
			return 16'(v);
		endfunction

		function void turn_unit(bit [31:0] ang, output longint c, output longint s);
			longint x, y, z, dx, dy;
			x = 64'sh26DD3B6A;
			y = 0;
			z = longint'(ang);
			if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
			if (z > 64'sh4000_0000) begin
				z -= 64'sh8000_0000;
				x = -x;
			end else if (z < -64'sh4000_0000) begin
				z += 64'sh8000_0000;
				x = -x;
			end
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(ATAN_STEP[i]);
				end else begin
					x += dx;
					y -= dy;
					z += longint'(ATAN_STEP[i]);
				end
			end
			c = x;
			s = y;
		endfunction

		function bit [31:0] heading_of(longint x, longint y);
			bit [31:0] z;
			longint dx, dy;
			z = 0;
			if (x == 0 && y == 0) return 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 32'h8000_0000;
			end
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx;
					y -= dy;
					z += ATAN_STEP[i];
				end else begin
					x -= dx;
					y += dy;
					z -= ATAN_STEP[i];
				end
			end
			return z;
		endfunction

		function void note_cmd(logic signed [15:0] vx, logic signed [15:0] vy,
				logic [15:0] hd, logic signed [15:0] om);
			res_t r;
			longint x, y, w, c, s, c2, s2, fix, scale, v, den;
			longint term [4];
			bit [31:0] dir, head;
			x = vx;
			y = vy;
			w = om;
			head = {hd, 16'h0};
			if (4 * (x * x + y * y) < longint'(low_lim) * longint'(low_lim)) begin
				r.a = clamp16(rnd_shr(w, 2));
				r.b = r.a;
				r.c = r.a;
				r.d = r.a;
				r.rot = 1'b1;
			end else begin
				dir = heading_of(x * 65536, y * 65536);
				turn_unit(head + 32'h2000_0000, c, s);
				turn_unit(head + dir, c2, s2);
				den = (c2 < 0 ? -c2 : c2) + (s2 < 0 ? -s2 : s2);
				fix = den != 0 ? (longint'(1518500250) <<< 30) / den : longint'(1) <<< 30;
				scale = longint'(out_max) - (w < 0 ? -w : w);
				term[0] = -x * s + y * c;
				term[1] = -x * c - y * s;
				term[2] = -term[0];
				term[3] = -term[1];
				for (int k = 0; k < 4; k++) begin
					v = rnd_shr(term[k], 15);
					v = rnd_shr(v * fix, 30);
					v = v * scale + (w <<< 30);
					term[k] = rnd_shr(v, 32);
				end
				r.a = clamp16(term[0]);
				r.b = clamp16(term[1]);
				r.c = clamp16(term[2]);
				r.d = clamp16(term[3]);
				r.rot = 1'b0;
			end
			wheels_due.push_back(r);
		endfunction

		function void check_wheels(res_t got);
			res_t want;
			if (wheels_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result a=%0d b=%0d c=%0d d=%0d rot=%0b",
					got.a, got.b, got.c, got.d, got.rot);
				return;
			end
			want = wheels_due.pop_front();
			if (got.a != want.a || got.b != want.b || got.c != want.c || got.d != want.d
					|| got.rot != want.rot) begin
				errors++;
				if (errors <= 10) $display(
					"wheel mismatch: exp %0d %0d %0d %0d rot %0b, got %0d %0d %0d %0d rot %0b",
					want.a, want.b, want.c, want.d, want.rot,
					got.a, got.b, got.c, got.d, got.rot);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;
	bit gaps_on;
	bit hold_long;

	omni_mix_cmd_if cmd_bus();
	omni_mix_res_if res_bus();

	wheel_mix_scoreboard sb = new();

	omni_wheel_vector_mixer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd_bus),
		.res(res_bus)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			sb.note_cmd(cmd_bus.vel_x, cmd_bus.vel_y, cmd_bus.heading, cmd_bus.rotate_rate);
		end
		if (arst_n && res_bus.valid && res_bus.ready) begin
			sb.check_wheels('{a: res_bus.wheel_a_drive, b: res_bus.wheel_b_drive,
				c: res_bus.wheel_c_drive, d: res_bus.wheel_d_drive,
				rot: res_bus.rotation_only});
		end
	end

	initial begin
		int n;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				n = 300;
				hold_long = 1'b0;
			end else begin
				n = gaps_on ? $urandom_range(0, 10) : 0;
			end
			if (n > 0) begin
				res_bus.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (!res_bus.valid) @(posedge clk);
		end
	end

	task automatic send_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] hd, logic [15:0] om);
		int gap;
		gap = gaps_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.vel_x <= vx;
		cmd_bus.vel_y <= vy;
		cmd_bus.heading <= hd;
		cmd_bus.rotate_rate <= om;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic drain();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.wheels_due.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	task automatic random_cmds(int count);
		logic [15:0] vx, vy, om;
		int lim;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) gaps_on = !gaps_on;
			lim = int'(sb.low_lim) / 2 + 2;
			om = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 8191) - 4096)
				: 16'($urandom());
			case ($urandom_range(0, 9))
				0, 1: begin
					vx = 16'($urandom_range(0, 2 * lim) - lim);
					vy = 16'($urandom_range(0, 2 * lim) - lim);
				end
				2: begin
					vx = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
					vy = 16'($urandom_range(0, 1) ? $urandom() : 0);
				end
				3: begin
					vx = 16'($urandom_range(0, 6) - 3);
					vy = 16'($urandom_range(0, 6) - 3);
				end
				default: begin
					vx = 16'($urandom());
					vy = 16'($urandom());
				end
			endcase
			send_cmd(vx, vy, 16'($urandom()), om);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		gaps_on = 1'b1;
		hold_long = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.vel_x = '0;
		cmd_bus.vel_y = '0;
		cmd_bus.heading = '0;
		cmd_bus.rotate_rate = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
		send_cmd(16'h0000, 16'h0000, 16'hFFFF, 16'h8000);
		send_cmd(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
		send_cmd(16'h8000, 16'h0000, 16'h4000, 16'h0000);
		send_cmd(16'h0000, 16'h7FFF, 16'h8000, 16'h2000);
		send_cmd(16'h0000, 16'h8000, 16'hC000, 16'hE000);
		send_cmd(16'h8000, 16'h8000, 16'h2000, 16'h7FFF);
		send_cmd(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000);
		send_cmd(16'h8000, 16'h7FFF, 16'h6000, 16'h0001);
		send_cmd(16'h0667, 16'h0000, 16'h0000, 16'h0000);
		send_cmd(16'h0666, 16'h0000, 16'h0000, 16'h0003);
		send_cmd(16'h0001, 16'hFFFF, 16'h1234, 16'hFFFD);
		send_cmd(16'h4000, 16'hC000, 16'hA000, 16'h4000);
		drain();

		write_reg(REG_LOW_LIMIT, 16'h0000);
		send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h1234);
		send_cmd(16'h0000, 16'h0000, 16'h5555, 16'h8000);
		send_cmd(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		random_cmds(300);
		drain();

		write_reg(REG_LOW_LIMIT, 16'hFFFF);
		write_reg(REG_OUTPUT_MAX, 16'h0000);
		random_cmds(200);
		drain();

		write_reg(REG_LOW_LIMIT, 16'd3277);
		write_reg(REG_OUTPUT_MAX, 16'hFFFF);
		gaps_on = 1'b0;
		hold_long = 1'b1;
		random_cmds(400);
		drain();

		write_reg(REG_SPARE_A, 16'h0000);
		write_reg(REG_SPARE_B, 16'hFFFF);
		write_reg(REG_LOW_LIMIT, 16'd1000);
		write_reg(REG_OUTPUT_MAX, 16'd16384);
		gaps_on = 1'b1;
		random_cmds(500);
		drain();

		write_reg(REG_LOW_LIMIT, 16'd20000);
		write_reg(REG_OUTPUT_MAX, 16'd40000);
		gaps_on = 1'b0;
		random_cmds(300);
		drain();

		write_reg(REG_LOW_LIMIT, 16'd3277);
		write_reg(REG_OUTPUT_MAX, 16'd32768);
		gaps_on = 1'b1;
		random_cmds(200);
		drain();

		if (sb.errors == 0 && sb.wheels_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
